// ===== src/nested_virtual_timer_accumulator_macros.svh =====
// Assertion macros shared by the timer accumulator RTL.
`ifndef NESTED_VIRTUAL_TIMER_ACCUMULATOR_MACROS_SVH
`define NESTED_VIRTUAL_TIMER_ACCUMULATOR_MACROS_SVH

`ifndef ASSERT_OFF

// Checked outside reset only.
`define NVTA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define NVTA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define NVTA_ASSERT(lbl, clk, rstn, prop, msg)
`define NVTA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== src/nvta_pkg.sv =====
// Types and constants of the nested virtual timer accumulator.
package nvta_pkg;

  localparam int NUM_CPUS = 8;
  localparam int CPU_W    = 3;
  localparam int IDX_W    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int CNT_W    = 16;
  localparam int TIME_W   = 48;
  localparam int TOTAL_W  = 64;
  localparam int TRUNC_W  = 32;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STOP  = 1'b1
  } action_e;

  typedef struct packed {
    action_e             action;
    logic [CPU_W-1:0]    cpu_index;
    logic [TIME_W-1:0]   counter_value;
  } cmd_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]  timer_total;
    logic [CNT_W-1:0]    nesting_count;
    logic                total_updated;
  } res_t;

endpackage

// ===== src/nvta_timer_bank.sv =====
// Per-CPU timer entries and their read-modify-write update.
`include "nested_virtual_timer_accumulator_macros.svh"

module nvta_timer_bank (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          delta_mode_i,
  input  nvta_pkg::cmd_t cmd_i,
  output nvta_pkg::res_t res_o
);
  import nvta_pkg::*;

  logic [CNT_W-1:0]   cnt_q   [NUM_CPUS];
  logic [TIME_W-1:0]  start_q [NUM_CPUS];
  logic [TOTAL_W-1:0] total_q [NUM_CPUS];

  logic [IDX_W-1:0]   idx;
  logic               in_range;
  logic [CNT_W-1:0]   cnt_rd;
  logic [TIME_W-1:0]  start_rd;
  logic [TOTAL_W-1:0] total_rd;
  logic [TOTAL_W-1:0] delta_full;
  logic [TOTAL_W-1:0] delta;
  logic [CNT_W-1:0]   cnt_d;
  logic [TIME_W-1:0]  start_d;
  logic [TOTAL_W-1:0] total_d;
  logic               updated;

  assign idx      = cmd_i.cpu_index[IDX_W-1:0];
  assign in_range = 32'(cmd_i.cpu_index) < NUM_CPUS;
  assign cnt_rd   = cnt_q[idx];
  assign start_rd = start_q[idx];
  assign total_rd = total_q[idx];

  // Counter may read below the start time; the 64-bit difference wraps.
  assign delta_full = {{(TOTAL_W-TIME_W){1'b0}}, cmd_i.counter_value}
                    - {{(TOTAL_W-TIME_W){1'b0}}, start_rd};
  assign delta = delta_mode_i ? {{(TOTAL_W-TRUNC_W){1'b0}}, delta_full[TRUNC_W-1:0]}
                              : delta_full;

  always_comb begin
    cnt_d   = cnt_rd;
    start_d = start_rd;
    total_d = total_rd;
    updated = 1'b0;
    case (cmd_i.action)
      ACT_START: begin
        // only the outermost start latches the time; count wraps
        if (cnt_rd == '0) start_d = cmd_i.counter_value;
        cnt_d = cnt_rd + CNT_W'(1);
      end
      ACT_STOP: begin
        if (cnt_rd != '0) begin
          cnt_d = cnt_rd - CNT_W'(1);
          if (cnt_rd == CNT_W'(1)) begin
            total_d = total_rd + delta;
            start_d = '0;
            updated = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o = '0;
    if (in_range) begin
      res_o.timer_total   = total_d;
      res_o.nesting_count = cnt_d;
      res_o.total_updated = updated;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CPUS; i++) begin
        cnt_q[i]   <= '0;
        start_q[i] <= '0;
        total_q[i] <= '0;
      end
    end else if (en_i && in_range) begin
      cnt_q[idx]   <= cnt_d;
      start_q[idx] <= start_d;
      total_q[idx] <= total_d;
    end
  end

  `NVTA_ASSERT(a_upd_closes, clk_i, rst_ni,
    res_o.total_updated |-> (res_o.nesting_count == '0 && cmd_i.action == ACT_STOP),
    "total update without closing the outermost interval")
  `NVTA_ASSERT(a_start_latch, clk_i, rst_ni,
    (en_i && in_range && cmd_i.action == ACT_START && cnt_rd == '0)
      |=> start_q[$past(idx)] == $past(cmd_i.counter_value),
    "outermost start did not latch the counter")

endmodule

// ===== src/nested_virtual_timer_accumulator.sv =====
// Top level: stream ports, input and result registers, mode register.
//
//  channel   | dir | beat content
//  ----------+-----+----------------------------------------------------
//  s_axis    | in  | tdata: counter_value; tuser: action, cpu_index
//  m_axis    | out | tdata: timer_total, nesting_count; tuser: total_updated
//  cfg       | in  | cfg_data_i: delta_mode
//
// One beat per cycle sustained while m_axis does not stall. Each beat is
// registered, then the addressed entry is read, updated and written back
// as the result is loaded into the output register, so consecutive beats
// to the same CPU see each other's update.
// Reset clears all entries and the mode; no sweep is needed after reset.
// A stalled m_axis holds one beat in each register, then drops s_axis_tready.
`include "nested_virtual_timer_accumulator_macros.svh"

module nested_virtual_timer_accumulator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,   // [47:0] counter_value
  input  logic [3:0]   s_axis_tuser,   // [0] action, [3:1] cpu_index
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [79:0]  m_axis_tdata,   // [63:0] timer_total, [79:64] nesting_count
  output logic [0:0]   m_axis_tuser,   // [0] total_updated
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [0:0]   cfg_data_i
);
  import nvta_pkg::*;

  logic   in_valid_q;
  cmd_t   in_cmd_q;
  logic   out_valid_q;
  res_t   out_res_q;
  res_t   bank_res;
  logic   advance;
  logic   delta_mode_q;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_mode_q <= 1'b0;
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) delta_mode_q <= cfg_data_i[0];
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q.action        <= action_e'(s_axis_tuser[0]);
      in_cmd_q.cpu_index     <= s_axis_tuser[3:1];
      in_cmd_q.counter_value <= s_axis_tdata;
    end
    if (advance) out_res_q <= bank_res;
  end

  nvta_timer_bank u_bank (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .delta_mode_i (delta_mode_q),
    .cmd_i        (in_cmd_q),
    .res_o        (bank_res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_res_q.nesting_count, out_res_q.timer_total};
  assign m_axis_tuser  = out_res_q.total_updated;

  `NVTA_ASSERT(a_held_beat, clk_i, rst_ni,
    (in_valid_q && !advance) |=> in_valid_q,
    "registered input beat dropped while blocked")
  `NVTA_ASSERT(a_result_loaded, clk_i, rst_ni,
    advance |=> out_valid_q,
    "processed beat produced no result")
  `NVTA_ASSERT_ALWAYS(a_ready_when_empty, clk_i,
    !in_valid_q |-> s_axis_tready,
    "input not ready with empty input register")

endmodule
